[rtl/wheel_speed_pi_pwm_loop_core_macros.svh]
// Assertion macros used by the top level of the wheel speed loop RTL.
`ifndef WHEEL_SPEED_PI_PWM_LOOP_CORE_MACROS_SVH
`define WHEEL_SPEED_PI_PWM_LOOP_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WSPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wspl: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WSPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wspl: next-cycle check failed");

`endif

[rtl/wspl_pkg.sv]
// Shared types, widths and register constants of the wheel speed PI loop.
package wspl_pkg;

    // Field widths
    localparam int CH_W   = 2;
    localparam int SPD_W  = 16;
    localparam int VOLT_W = 10;
    localparam int ERR_W  = SPD_W + 1;
    localparam int ACC_W  = 32;
    localparam int DRV_W  = 16;
    localparam int CMP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;
    localparam int POL_W  = 4;

    // Parameter defaults
    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_FRAC_BITS = 12;

    // APB port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (word address)
    localparam logic [2:0] REG_KP          = 3'd0;
    localparam logic [2:0] REG_KI          = 3'd1;
    localparam logic [2:0] REG_DRIVE_LIMIT = 3'd2;
    localparam logic [2:0] REG_PWM_PERIOD  = 3'd3;
    localparam logic [2:0] REG_MIN_VOLTAGE = 3'd4;
    localparam logic [2:0] REG_POLARITY    = 3'd5;

    // Register reset values
    localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT = LIM_W'(16700);
    localparam logic [CMP_W-1:0]  RST_PWM_PERIOD  = CMP_W'(16799);
    localparam logic [VOLT_W-1:0] RST_MIN_VOLTAGE = VOLT_W'(100);
    localparam logic [POL_W-1:0]  RST_POLARITY    = POL_W'(6);

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [LIM_W-1:0]  drive_limit;
        logic [CMP_W-1:0]  pwm_period;
        logic [VOLT_W-1:0] min_voltage;
        logic [POL_W-1:0]  polarity_mask;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [ACC_W-1:0] acc;
        logic signed [ERR_W-1:0] prev_err;
    } t_state_wr;

endpackage

[rtl/wspl_apb_regs.sv]
// APB configuration register bank of the wheel speed PI loop.
module wspl_apb_regs
    import wspl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = i_paddr[4:2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    // Write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp            <= '0;
            r_cfg.ki            <= '0;
            r_cfg.drive_limit   <= RST_DRIVE_LIMIT;
            r_cfg.pwm_period    <= RST_PWM_PERIOD;
            r_cfg.min_voltage   <= RST_MIN_VOLTAGE;
            r_cfg.polarity_mask <= RST_POLARITY;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KP:          r_cfg.kp            <= i_pwdata[GAIN_W-1:0];
                REG_KI:          r_cfg.ki            <= i_pwdata[GAIN_W-1:0];
                REG_DRIVE_LIMIT: r_cfg.drive_limit   <= i_pwdata[LIM_W-1:0];
                REG_PWM_PERIOD:  r_cfg.pwm_period    <= i_pwdata[CMP_W-1:0];
                REG_MIN_VOLTAGE: r_cfg.min_voltage   <= i_pwdata[VOLT_W-1:0];
                REG_POLARITY:    r_cfg.polarity_mask <= i_pwdata[POL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_KP:          o_prdata = APB_DATA_W'(r_cfg.kp);
            REG_KI:          o_prdata = APB_DATA_W'(r_cfg.ki);
            REG_DRIVE_LIMIT: o_prdata = APB_DATA_W'(r_cfg.drive_limit);
            REG_PWM_PERIOD:  o_prdata = APB_DATA_W'(r_cfg.pwm_period);
            REG_MIN_VOLTAGE: o_prdata = APB_DATA_W'(r_cfg.min_voltage);
            REG_POLARITY:    o_prdata = APB_DATA_W'(r_cfg.polarity_mask);
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/wspl_chan_state.sv]
// Per-channel accumulator and previous error registers.
module wspl_chan_state
    import wspl_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CH_W-1:0]         i_rd_channel,
    output logic signed [ACC_W-1:0] o_rd_acc,
    output logic signed [ERR_W-1:0] o_rd_prev_err,
    input  logic                    i_wr_en,
    input  t_state_wr               i_wr
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [ACC_W-1:0] r_acc      [CHANNELS];
    logic signed [ERR_W-1:0] r_prev_err [CHANNELS];
    logic [IDX_W-1:0]        rd_idx;
    logic [IDX_W-1:0]        wr_idx;
    logic                    rd_ok;
    logic                    wr_ok;

    assign rd_idx = IDX_W'(i_rd_channel);
    assign wr_idx = IDX_W'(i_wr.channel);
    assign rd_ok  = (int'(i_rd_channel) < CHANNELS);
    assign wr_ok  = (int'(i_wr.channel) < CHANNELS);

    // Read the selected channel; channels past the end read as zero
    assign o_rd_acc      = rd_ok ? r_acc[rd_idx]      : '0;
    assign o_rd_prev_err = rd_ok ? r_prev_err[rd_idx] : '0;

    // Clear on reset, update one channel per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_acc[i]      <= '0;
                r_prev_err[i] <= '0;
            end
        end else if (i_wr_en && wr_ok) begin
            r_acc[wr_idx]      <= i_wr.acc;
            r_prev_err[wr_idx] <= i_wr.prev_err;
        end
    end

endmodule

[rtl/wspl_pi_step.sv]
// One incremental PI step with saturation and H-bridge compare mapping.
module wspl_pi_step
    import wspl_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  t_cfg                    i_cfg,
    input  logic [CH_W-1:0]         i_channel,
    input  logic signed [SPD_W-1:0] i_measured_speed,
    input  logic signed [SPD_W-1:0] i_target_speed,
    input  logic [VOLT_W-1:0]       i_battery_voltage,
    input  logic                    i_enable_switch,
    input  logic                    i_stop_request,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic signed [ERR_W-1:0] i_prev_err,
    output logic signed [DRV_W-1:0] o_drive_value,
    output logic [CMP_W-1:0]        o_compare_first,
    output logic [CMP_W-1:0]        o_compare_second,
    output logic                    o_running,
    output t_state_wr               o_wr
);

    localparam int SUM_W = ACC_W + 5;
    localparam logic signed [ACC_W:0] ROUND_ADD = (ACC_W + 1)'((64'(1) << FRAC_BITS) - 1);

    logic signed [ERR_W-1:0]        err;
    logic signed [ERR_W:0]          derr;
    logic signed [GAIN_W+ERR_W+1:0] p_term;
    logic signed [GAIN_W+ERR_W:0]   i_term;
    logic signed [SUM_W-1:0]        acc_sum;
    logic signed [SUM_W-1:0]        bound;
    logic signed [SUM_W-1:0]        acc_sat;
    logic signed [ACC_W-1:0]        acc_new;
    logic signed [ACC_W:0]          acc_adj;
    logic signed [DRV_W-1:0]        drv_mag;
    logic signed [DRV_W-1:0]        drive;
    logic signed [CMP_W+1:0]        period_s;
    logic signed [CMP_W+1:0]        c_side;
    logic [CMP_W-1:0]               c_clamped;

    // Stop conditions
    assign o_running = (int'(i_channel) < CHANNELS)
                    && (i_battery_voltage >= i_cfg.min_voltage)
                    && i_enable_switch && !i_stop_request;

    // Error and its change
    assign err  = ERR_W'(i_target_speed) - ERR_W'(i_measured_speed);
    assign derr = (ERR_W + 1)'(err) - (ERR_W + 1)'(i_prev_err);

    // Gain products
    assign p_term = $signed({1'b0, i_cfg.kp}) * derr;
    assign i_term = $signed({1'b0, i_cfg.ki}) * err;

    // Accumulate and saturate
    assign acc_sum = SUM_W'(i_acc) + SUM_W'(p_term) + SUM_W'(i_term);
    assign bound   = $signed(SUM_W'(i_cfg.drive_limit) << FRAC_BITS);

    always_comb begin
        if (acc_sum > bound) begin
            acc_sat = bound;
        end else if (acc_sum < -bound) begin
            acc_sat = -bound;
        end else begin
            acc_sat = acc_sum;
        end
    end

    assign acc_new = ACC_W'(acc_sat);

    // Integer drive, truncated toward zero, then polarity
    assign acc_adj = (ACC_W + 1)'(acc_new) + (acc_new[ACC_W-1] ? ROUND_ADD : '0);
    assign drv_mag = DRV_W'(acc_adj >>> FRAC_BITS);
    assign drive   = i_cfg.polarity_mask[i_channel] ? -drv_mag : drv_mag;

    // Bridge compares: the active side moves down from the period, floor at zero
    assign period_s  = $signed({2'b00, i_cfg.pwm_period});
    assign c_side    = drive[DRV_W-1] ? period_s + (CMP_W + 2)'(drive)
                                      : period_s - (CMP_W + 2)'(drive);
    assign c_clamped = c_side[CMP_W+1] ? '0 : c_side[CMP_W-1:0];

    always_comb begin
        if (!o_running) begin
            o_drive_value    = '0;
            o_compare_first  = i_cfg.pwm_period;
            o_compare_second = i_cfg.pwm_period;
        end else if (drive[DRV_W-1]) begin
            o_drive_value    = drive;
            o_compare_first  = i_cfg.pwm_period;
            o_compare_second = c_clamped;
        end else begin
            o_drive_value    = drive;
            o_compare_first  = c_clamped;
            o_compare_second = i_cfg.pwm_period;
        end
    end

    // State write-back for this channel
    assign o_wr.channel  = i_channel;
    assign o_wr.acc      = acc_new;
    assign o_wr.prev_err = err;

endmodule

[rtl/wheel_speed_pi_pwm_loop_core.sv]
// Top level of the four-channel wheel speed PI loop with H-bridge compares.
//
// Input channel: i_in_valid / o_in_ready move one sample (wheel channel,
// measured and target speed, battery voltage, enable switch, stop request).
// Output channel: o_out_valid / i_out_ready move one result per sample
// (channel, drive value, two bridge compares, running flag), in order.
// Configuration: APB port, six registers at byte addresses 0..20,
// pready tied high. The user must write them only while no sample is in
// flight; the block itself does not enforce this.
// Path: a transferred sample is captured in the input register, then one
// pass of PI logic feeds the result register, which drives the output.
// Throughput: one sample per cycle while the receiver does not stall,
// set by the single read-modify-write of the channel state at the
// result register edge, so back-to-back samples of the same wheel see
// each other's update.
// Reset (synchronous, active low) clears both pipeline valids, all channel
// state and loads the register defaults. When the receiver stalls, the
// result register holds and the input register keeps accepting until it
// is full too; then o_in_ready drops.
module wheel_speed_pi_pwm_loop_core
    import wspl_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CH_W-1:0]         i_channel,
    input  logic signed [SPD_W-1:0] i_measured_speed,
    input  logic signed [SPD_W-1:0] i_target_speed,
    input  logic [VOLT_W-1:0]       i_battery_voltage,
    input  logic                    i_enable_switch,
    input  logic                    i_stop_request,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CH_W-1:0]         o_out_channel,
    output logic signed [DRV_W-1:0] o_drive_value,
    output logic [CMP_W-1:0]        o_compare_first,
    output logic [CMP_W-1:0]        o_compare_second,
    output logic                    o_running,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

`include "wheel_speed_pi_pwm_loop_core_macros.svh"

    t_cfg                    cfg;
    t_state_wr               st_wr;
    logic signed [ACC_W-1:0] st_acc;
    logic signed [ERR_W-1:0] st_prev_err;

    // input register
    logic                    r_in_valid;
    logic [CH_W-1:0]         r_channel;
    logic signed [SPD_W-1:0] r_measured_speed;
    logic signed [SPD_W-1:0] r_target_speed;
    logic [VOLT_W-1:0]       r_battery_voltage;
    logic                    r_enable_switch;
    logic                    r_stop_request;

    // result register
    logic                    r_out_valid;
    logic [CH_W-1:0]         r_out_channel;
    logic signed [DRV_W-1:0] r_drive_value;
    logic [CMP_W-1:0]        r_compare_first;
    logic [CMP_W-1:0]        r_compare_second;
    logic                    r_running;

    logic                    n_drive_sign;
    logic signed [DRV_W-1:0] n_drive_value;
    logic [CMP_W-1:0]        n_compare_first;
    logic [CMP_W-1:0]        n_compare_second;
    logic                    n_running;
    logic                    advance;
    logic                    in_xfer;

    assign pready  = 1'b1;
    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer = i_in_valid && o_in_ready;

    wspl_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    wspl_chan_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_channel  (r_channel),
        .o_rd_acc      (st_acc),
        .o_rd_prev_err (st_prev_err),
        .i_wr_en       (advance && n_running),
        .i_wr          (st_wr)
    );

    wspl_pi_step #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .i_cfg             (cfg),
        .i_channel         (r_channel),
        .i_measured_speed  (r_measured_speed),
        .i_target_speed    (r_target_speed),
        .i_battery_voltage (r_battery_voltage),
        .i_enable_switch   (r_enable_switch),
        .i_stop_request    (r_stop_request),
        .i_acc             (st_acc),
        .i_prev_err        (st_prev_err),
        .o_drive_value     (n_drive_value),
        .o_compare_first   (n_compare_first),
        .o_compare_second  (n_compare_second),
        .o_running         (n_running),
        .o_wr              (st_wr)
    );

    assign n_drive_sign = n_drive_value[DRV_W-1];

    // Input register: load on transfer, drop when passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_channel         <= i_channel;
            r_measured_speed  <= i_measured_speed;
            r_target_speed    <= i_target_speed;
            r_battery_voltage <= i_battery_voltage;
            r_enable_switch   <= i_enable_switch;
            r_stop_request    <= i_stop_request;
        end
    end

    // Result register: load on advance, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_channel    <= r_channel;
            r_drive_value    <= n_drive_value;
            r_compare_first  <= n_compare_first;
            r_compare_second <= n_compare_second;
            r_running        <= n_running;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out_channel;
    assign o_drive_value    = r_drive_value;
    assign o_compare_first  = r_compare_first;
    assign o_compare_second = r_compare_second;
    assign o_running        = r_running;

    // A stopped result has zero drive and both sides fully off
    `WSPL_ASSERT_NOW(a_stop_off, i_clk, i_rst_n, o_out_valid && !o_running,
        (o_drive_value == '0) && (o_compare_first == o_compare_second))

    // Only the side opposite the drive sign leaves the period
    `WSPL_ASSERT_NOW(a_side_select, i_clk, i_rst_n, o_out_valid && o_running,
        o_drive_value[DRV_W-1] ? (o_compare_first == cfg.pwm_period)
                               : (o_compare_second == cfg.pwm_period))

    // A step taken always shows up as a result in the next cycle
    `WSPL_ASSERT_NEXT(a_advance_out, i_clk, i_rst_n, advance,
        o_out_valid && (o_drive_value[DRV_W-1] == $past(n_drive_sign)))

endmodule
